/* hw/rtl/quaternion_arith_unit_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef QUATERNION_ARITH_UNIT_TOP_MACROS_SVH
`define QUATERNION_ARITH_UNIT_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define QAU_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qau assertion failed");

// Next-cycle implication, masked while reset is high.
`define QAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qau assertion failed");

// Next-cycle implication that also holds across reset.
`define QAU_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qau assertion failed");

`endif

/* hw/rtl/qau_pkg.sv */
package qau_pkg;

  localparam int FRAC_BITS = 12;
  localparam int WORD_BITS = 16;
  localparam int TOL_BITS  = 12;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(4);

  // derived widths
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int SUM_W  = 2 * WORD_BITS + 2;
  localparam int ROOT_W = WORD_BITS + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int LEN_W  = WORD_BITS + 2;
  localparam int QW     = FRAC_BITS + 2;
  localparam int DW     = WORD_BITS + FRAC_BITS + 1;
  localparam int SAT_W  = (SUM_W > QW + 1) ? SUM_W : QW + 1;
  localparam int DIFF_W = ((LEN_W > FRAC_BITS + 1) ? LEN_W : FRAC_BITS + 1) + 1;

  typedef enum logic [1:0] {
    MODE_MUL  = 2'd0,
    MODE_CONJ = 2'd1,
    MODE_NORM = 2'd2,
    MODE_LEN  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  // one square-root digit step
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // one quotient bit step, four lanes sharing one divisor
  typedef struct packed {
    logic [LEN_W-1:0]         len;
    logic [3:0][LEN_W-1:0]    rem;
    logic [3:0][QW-1:0]       num;
    logic [3:0][QW-1:0]       quo;
  } div_t;

  // request context carried down the pipe
  typedef struct packed {
    mode_t                     mode;
    logic [3:0]                neg;
    logic [3:0][WORD_BITS-1:0] a;
    logic [3:0][WORD_BITS-1:0] r;
    status_t                   status;
    logic [WORD_BITS-1:0]      mag;
    logic                      use_div;
  } item_t;

  // clamp to the signed word range; returns {saturated, word}
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic [WORD_BITS:0] res;
    if (v[SAT_W-1:WORD_BITS-1] == {(SAT_W-WORD_BITS+1){v[SAT_W-1]}}) begin
      res = {1'b0, v[WORD_BITS-1:0]};
    end else if (v[SAT_W-1]) begin
      res = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/qau_if.sv */
// Request channel
interface qau_in_if;
  import qau_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic signed [WORD_BITS-1:0] a_w;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] a_z;
  logic signed [WORD_BITS-1:0] b_w;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;
  modport source (output valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                output ready);
endinterface

// Result channel
interface qau_out_if;
  import qau_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] r_w;
  logic signed [WORD_BITS-1:0] r_x;
  logic signed [WORD_BITS-1:0] r_y;
  logic signed [WORD_BITS-1:0] r_z;
  logic [WORD_BITS-1:0]        magnitude;
  logic [1:0]                  status;
  modport source (output valid, r_w, r_x, r_y, r_z, magnitude, status, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, magnitude, status, output ready);
endinterface

/* hw/rtl/qau_sqrt_cell.sv */
module qau_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  qau_pkg::sqrt_t din,
  output qau_pkg::sqrt_t dout
);
  import qau_pkg::*;

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] sub;
  sqrt_t            nxt;

  // bring in two radicand bits, try subtracting 4*root+1
  always_comb begin
    cur      = {din.rem, din.rad[RAD_W-1 -: 2]};
    sub      = {{(REM_W-ROOT_W){1'b0}}, din.root, 2'b01};
    nxt.rad  = {din.rad[RAD_W-3:0], 2'b00};
    if (cur >= sub) begin
      nxt.rem  = REM_W'(cur - sub);
      nxt.root = {din.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = cur[REM_W-1:0];
      nxt.root = {din.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* hw/rtl/qau_div_cell.sv */
module qau_div_cell (
  input  logic         clk,
  input  logic         en,
  input  qau_pkg::div_t din,
  output qau_pkg::div_t dout
);
  import qau_pkg::*;

  logic [LEN_W:0] cur [4];
  div_t           nxt;

  // one restoring step per lane
  always_comb begin
    nxt.len = din.len;
    for (int i = 0; i < 4; i++) begin
      cur[i]     = {din.rem[i], din.num[i][QW-1]};
      nxt.num[i] = {din.num[i][QW-2:0], 1'b0};
      if (cur[i] >= {1'b0, din.len}) begin
        nxt.rem[i] = LEN_W'(cur[i] - {1'b0, din.len});
        nxt.quo[i] = {din.quo[i][QW-2:0], 1'b1};
      end else begin
        nxt.rem[i] = cur[i][LEN_W-1:0];
        nxt.quo[i] = {din.quo[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* hw/rtl/quaternion_arith_unit_top.sv */
// Structure: 2 arithmetic stages, 17 root cells, 1 decision stage, 14 quotient cells,
//   1 output register.
// Throughput: one request per cycle; the whole pipe stalls only when the output
//   register holds a result that is not taken.
// Reset (rst, synchronous): empties the pipe and sets the tolerance register tol to 4.
module quaternion_arith_unit_top (
  input  logic                           clk,
  input  logic                           rst,
  qau_in_if.sink                         in_ch,
  qau_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [qau_pkg::TOL_BITS-1:0]   cfg_wdata
);
  import qau_pkg::*;

  localparam int NS  = ROOT_W;
  localparam int ND  = QW;
  localparam int LAT = NS + ND + 4;

  logic                  adv;
  logic [LAT-1:0]        vld;
  logic [TOL_BITS-1:0]   tol;

  // global advance: move when the output register is free or being taken
  assign adv         = ~vld[LAT-1] | out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // stage A: products and squares
  logic signed [WORD_BITS-1:0] ia [4];
  logic signed [WORD_BITS-1:0] ib [4];
  logic signed [PROD_W-1:0]    prod [16];
  logic signed [PROD_W-1:0]    sqr [4];
  item_t                       itm_a;

  assign ia[0] = in_ch.a_w;
  assign ia[1] = in_ch.a_x;
  assign ia[2] = in_ch.a_y;
  assign ia[3] = in_ch.a_z;
  assign ib[0] = in_ch.b_w;
  assign ib[1] = in_ch.b_x;
  assign ib[2] = in_ch.b_y;
  assign ib[3] = in_ch.b_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      // w terms: a0b0, a1b1, a2b2, a3b3 (last three subtracted)
      prod[0]  <= ia[0] * ib[0];
      prod[1]  <= ia[1] * ib[1];
      prod[2]  <= ia[2] * ib[2];
      prod[3]  <= ia[3] * ib[3];
      // x terms
      prod[4]  <= ia[0] * ib[1];
      prod[5]  <= ib[0] * ia[1];
      prod[6]  <= ia[2] * ib[3];
      prod[7]  <= ia[3] * ib[2];
      // y terms
      prod[8]  <= ia[0] * ib[2];
      prod[9]  <= ib[0] * ia[2];
      prod[10] <= ia[3] * ib[1];
      prod[11] <= ia[1] * ib[3];
      // z terms
      prod[12] <= ia[0] * ib[3];
      prod[13] <= ib[0] * ia[3];
      prod[14] <= ia[1] * ib[2];
      prod[15] <= ia[2] * ib[1];
      for (int i = 0; i < 4; i++) begin
        sqr[i] <= ia[i] * ia[i];
      end
      itm_a.mode    <= mode_t'(in_ch.mode);
      itm_a.a       <= {ia[3], ia[2], ia[1], ia[0]};
      itm_a.neg     <= {ia[3][WORD_BITS-1], ia[2][WORD_BITS-1],
                        ia[1][WORD_BITS-1], ia[0][WORD_BITS-1]};
      itm_a.r       <= '0;
      itm_a.status  <= ST_OK;
      itm_a.mag     <= '0;
      itm_a.use_div <= 1'b0;
    end
  end

  // stage B: product sums with rounding, conjugate, sum of squares
  logic signed [SUM_W-1:0] term [16];
  logic signed [SUM_W-1:0] hsum [4];
  logic signed [SUM_W-1:0] hshift [4];
  logic [WORD_BITS:0]      hsat [4];
  logic [WORD_BITS:0]      csat [4];
  logic [RAD_W-1:0]        sqsum;
  item_t                   itm_b_next;
  item_t                   itm_s [NS+1];
  sqrt_t                   sq [NS+1];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      // the first term of each group adds, in w all others subtract,
      // elsewhere only the last one subtracts
      if ((k < 4 && k != 0) || (k >= 4 && (k % 4) == 3)) begin
        term[k] = -SUM_W'(prod[k]);
      end else begin
        term[k] = SUM_W'(prod[k]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      hsum[i]   = term[4*i] + term[4*i+1] + term[4*i+2] + term[4*i+3]
                + (SUM_W'(1) <<< (FRAC_BITS - 1));
      hshift[i] = hsum[i] >>> FRAC_BITS;
      hsat[i]   = sat_word(SAT_W'(hshift[i]));
      csat[i]   = sat_word(-SAT_W'($signed(itm_a.a[i])));
    end
    sqsum = RAD_W'(sqr[0][PROD_W-2:0]) + RAD_W'(sqr[1][PROD_W-2:0])
          + RAD_W'(sqr[2][PROD_W-2:0]) + RAD_W'(sqr[3][PROD_W-2:0]);

    itm_b_next = itm_a;
    case (itm_a.mode)
      MODE_MUL: begin
        for (int i = 0; i < 4; i++) begin
          itm_b_next.r[i] = hsat[i][WORD_BITS-1:0];
        end
        itm_b_next.status = (hsat[0][WORD_BITS] | hsat[1][WORD_BITS] |
                             hsat[2][WORD_BITS] | hsat[3][WORD_BITS]) ? ST_SAT : ST_OK;
      end
      MODE_CONJ: begin
        itm_b_next.r[0] = itm_a.a[0];
        for (int i = 1; i < 4; i++) begin
          itm_b_next.r[i] = csat[i][WORD_BITS-1:0];
        end
        itm_b_next.status = (csat[1][WORD_BITS] | csat[2][WORD_BITS] |
                             csat[3][WORD_BITS]) ? ST_SAT : ST_OK;
      end
      default: begin
        itm_b_next.status = ST_OK;
      end
    endcase
  end

  // stage B register and request context alongside the root cells
  always_ff @(posedge clk) begin
    if (adv) begin
      itm_s[0]   <= itm_b_next;
      sq[0].rad  <= sqsum;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      for (int k = 0; k < NS; k++) begin
        itm_s[k+1] <= itm_s[k];
      end
    end
  end

  // square-root cell chain, one result bit per cell
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    qau_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .din  (sq[k]),
      .dout (sq[k+1])
    );
  end

  // stage C: rounded length, normalize decisions, divider setup
  logic [LEN_W-1:0]           len;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          adiff;
  logic [WORD_BITS-1:0]       absa [4];
  logic [DW-1:0]              dvd [4];
  item_t                      itm_c_next;
  div_t                       div_c_next;
  item_t                      itm_d [ND+1];
  div_t                       dv [ND+1];

  always_comb begin
    len = LEN_W'(sq[NS].root) +
          LEN_W'({{(REM_W-1){1'b0}}, (sq[NS].rem > REM_W'(sq[NS].root))});
    diff  = $signed(DIFF_W'(len)) - (DIFF_W'(1) <<< FRAC_BITS);
    adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    itm_c_next     = itm_s[NS];
    itm_c_next.mag = (len > LEN_W'({WORD_BITS{1'b1}})) ? {WORD_BITS{1'b1}}
                                                        : len[WORD_BITS-1:0];
    div_c_next.len = len;
    for (int i = 0; i < 4; i++) begin
      absa[i] = itm_s[NS].neg[i] ? (~itm_s[NS].a[i] + WORD_BITS'(1)) : itm_s[NS].a[i];
      dvd[i]  = DW'({absa[i], {FRAC_BITS{1'b0}}}) + DW'(len >> 1);
      div_c_next.rem[i] = LEN_W'(dvd[i] >> QW);
      div_c_next.num[i] = dvd[i][QW-1:0];
      div_c_next.quo[i] = '0;
    end

    case (itm_s[NS].mode)
      MODE_NORM: begin
        if (len == '0) begin
          itm_c_next.r      = '0;
          itm_c_next.status = ST_ZERO;
        end else if (adiff < DIFF_W'(tol)) begin
          itm_c_next.r      = itm_s[NS].a;
          itm_c_next.status = ST_OK;
        end else begin
          itm_c_next.use_div = 1'b1;
        end
      end
      MODE_LEN: begin
        itm_c_next.r      = '0;
        itm_c_next.status = (len > LEN_W'({WORD_BITS{1'b1}})) ? ST_SAT : ST_OK;
      end
      default: begin
        itm_c_next.use_div = 1'b0;
      end
    endcase
  end

  // stage C register and request context alongside the quotient cells
  always_ff @(posedge clk) begin
    if (adv) begin
      itm_d[0] <= itm_c_next;
      dv[0]    <= div_c_next;
      for (int k = 0; k < ND; k++) begin
        itm_d[k+1] <= itm_d[k];
      end
    end
  end

  // quotient cell chain, one quotient bit per cell, four lanes
  for (genvar k = 0; k < ND; k++) begin : g_div
    qau_div_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .din  (dv[k]),
      .dout (dv[k+1])
    );
  end

  // stage D: apply signs to quotients, output register
  logic signed [SAT_W-1:0] qs [4];
  logic [WORD_BITS:0]      qsat [4];
  item_t                   fin;
  item_t                   out_q;

  always_comb begin
    fin = itm_d[ND];
    for (int i = 0; i < 4; i++) begin
      qs[i]   = itm_d[ND].neg[i] ? -SAT_W'(dv[ND].quo[i]) : SAT_W'(dv[ND].quo[i]);
      qsat[i] = sat_word(qs[i]);
    end
    if (itm_d[ND].use_div) begin
      for (int i = 0; i < 4; i++) begin
        fin.r[i] = qsat[i][WORD_BITS-1:0];
      end
      fin.status = (qsat[0][WORD_BITS] | qsat[1][WORD_BITS] |
                    qsat[2][WORD_BITS] | qsat[3][WORD_BITS]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q <= fin;
    end
  end

  assign out_ch.valid     = vld[LAT-1];
  assign out_ch.r_w       = out_q.r[0];
  assign out_ch.r_x       = out_q.r[1];
  assign out_ch.r_y       = out_q.r[2];
  assign out_ch.r_z       = out_q.r[3];
  assign out_ch.magnitude = out_q.mag;
  assign out_ch.status    = out_q.status;

endmodule

/* hw/rtl/qau_checker.sv */
`include "quaternion_arith_unit_top_macros.svh"

module qau_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [qau_pkg::WORD_BITS-1:0]     r_w,
  input logic [qau_pkg::WORD_BITS-1:0]     r_x,
  input logic [qau_pkg::WORD_BITS-1:0]     r_y,
  input logic [qau_pkg::WORD_BITS-1:0]     r_z,
  input logic [qau_pkg::WORD_BITS-1:0]     magnitude,
  input logic [1:0]                        status
);
  import qau_pkg::*;

  // request side is blocked only by an untaken result
  `QAU_ASSERT(a_ready_flow, in_valid || !in_valid, in_ready == (!out_valid || out_ready))
  // a stalled result stays valid and holds its status, r_w and magnitude
  `QAU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(r_w) && $stable(magnitude))
  // zero-length normalize reports zero length and zero components
  `QAU_ASSERT(a_zero_len, out_valid && status == ST_ZERO, r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0 && magnitude == '0)
  // reset empties the pipe
  `QAU_ASSERT_RST(a_rst_empty, rst, !out_valid)

endmodule

bind quaternion_arith_unit_top qau_checker u_qau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .r_w       (out_ch.r_w),
  .r_x       (out_ch.r_x),
  .r_y       (out_ch.r_y),
  .r_z       (out_ch.r_z),
  .magnitude (out_ch.magnitude),
  .status    (out_ch.status)
);
